>>> rtl/tcof_pkg.sv
// Package for the text cat output formatter: payload and command types,
// configuration register codes, sequencer phases and character constants.
// Depends on nothing; each rtl file but tcof_queue uses it by scoped names.
`default_nettype none

package tcof_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 8;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] CH_CAP_I  = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_CTRL_MAX   = 8'd31;
  localparam logic [7:0] CARET_OFFSET  = 8'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_NONPRINTING = 3'd4,
    CFG_SHOW_TABS        = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_nonprinting;
    logic show_tabs;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Classified request as queued between the front and the back. The line
  // number digits travel next to it, since their count is a parameter.
  typedef struct packed {
    logic       num;
    logic       dollar;
    logic       caret;
    logic [7:0] chr;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_TAB,
    PH_DOLLAR,
    PH_CARET,
    PH_CHAR
  } phase_e;

endpackage

`default_nettype wire

>>> rtl/text_cat_output_formatter_core.sv
// Top level of the text cat output formatter: configuration registers, front
// end, decoupling queue and back end. Depends on tcof_pkg, tcof_front,
// tcof_queue and tcof_back.
//
// Usage. Raw text bytes enter through a queue-like port: a request is taken
// at a clock edge with push high and full low. Results leave through a second
// queue-like port: while empty is low, out_o holds the oldest output byte and
// it is taken at an edge with pop high. The last flag marks the final output
// byte that belongs to one input byte. A squeezed blank line yields nothing.
// Options are written through the cfg port (always ready) while the block is
// idle; the register index follows the option list, and bit 0 is the value.
// A request's first byte reaches out_o via the queue and then the back end's
// single output register, which also sets the throughput: one output byte per
// cycle while the receiver pops. A request that expands to k bytes (k up to
// NUMBER_DIGITS + 3) holds the back end until all k are out, so plain bytes
// flow at one per cycle while popped. The queue of QUEUE_DEPTH commands lets
// the front keep taking requests while the back drains an expansion, and full
// rises once it fills. A stalled receiver holds out_o; nothing is dropped.
// Reset clears all options, puts the line state at line start with no prior
// blank line, loads line number one, and empties the queue and the output.

`default_nettype none

module text_cat_output_formatter_core #(
  parameter int NUMBER_DIGITS = tcof_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tcof_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               push,
  output logic                              full,
  input  tcof_pkg::in_item_t                in_i,
  output logic                              empty,
  input  wire                               pop,
  output tcof_pkg::out_item_t               out_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [tcof_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire  [tcof_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int LN_W = NUMBER_DIGITS * 4;
  localparam int Q_W  = LN_W + $bits(tcof_pkg::cmd_t);

  tcof_pkg::cfg_t  cfg_q, cfg_d;
  tcof_pkg::cmd_t  front_cmd, head_cmd;
  logic [LN_W-1:0] front_digits, head_digits;
  logic            q_wr, q_full, q_rd, q_valid;
  logic [Q_W-1:0]  q_rdata;

  // Option registers. The port never stalls; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tcof_pkg::CFG_NUMBER_ALL:       cfg_d.number_all       = cfg_data_i[0];
        tcof_pkg::CFG_NUMBER_NONBLANK:  cfg_d.number_nonblank  = cfg_data_i[0];
        tcof_pkg::CFG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_data_i[0];
        tcof_pkg::CFG_SHOW_ENDS:        cfg_d.show_ends        = cfg_data_i[0];
        tcof_pkg::CFG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_data_i[0];
        tcof_pkg::CFG_SHOW_TABS:        cfg_d.show_tabs        = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each byte and updates line state at acceptance.
  tcof_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .push_i  (push),
    .full_i  (q_full),
    .item_i  (in_i),
    .wr_o    (q_wr),
    .cmd_o   (front_cmd),
    .digits_o(front_digits)
  );

  assign full = q_full;

  // The queue carries the command together with its line number snapshot.
  tcof_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i({front_digits, front_cmd}),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o(q_rdata),
    .valid_o(q_valid)
  );

  assign head_digits = q_rdata[Q_W-1 -: LN_W];
  assign head_cmd    = q_rdata[$bits(tcof_pkg::cmd_t)-1:0];

  // The back end expands the head command, one byte per cycle while popped.
  tcof_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (head_cmd),
    .digits_i(head_digits),
    .rd_o    (q_rd),
    .pop_i   (pop),
    .empty_o (empty),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // A result can only appear when a command was waiting at the queue head.
  a_result_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(!empty) |-> $past(q_valid))
    else $error("result appeared without a queued command");

  // A command leaves the queue only together with its final output byte.
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |=> (!empty && out_o.last))
    else $error("command retired without a final byte");

  // While the receiver stalls a waiting result, the back end does not advance.
  a_stall_holds_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |-> !q_rd)
    else $error("back end advanced during an output stall");
`endif

endmodule

`default_nettype wire

>>> rtl/tcof_front.sv
// Front end of the formatter: accepts input requests, tracks line state and
// the BCD line counter, and queues one classified command per kept byte.
// Depends on tcof_pkg.
`default_nettype none

module tcof_front #(
  parameter int NUMBER_DIGITS = tcof_pkg::NUMBER_DIGITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  tcof_pkg::cfg_t             cfg_i,
  input  wire                        push_i,
  input  wire                        full_i,
  input  tcof_pkg::in_item_t         item_i,
  output logic                       wr_o,
  output tcof_pkg::cmd_t             cmd_o,
  output logic [NUMBER_DIGITS*4-1:0] digits_o
);

  localparam int LN_W = NUMBER_DIGITS * 4;
  localparam logic [LN_W-1:0] LN_ONE = {{(LN_W-1){1'b0}}, 1'b1};

  logic            at_line_start_q, at_line_start_d;
  logic            prior_blank_q, prior_blank_d;
  logic [LN_W-1:0] line_number_q, line_number_d;

  logic            ls, pb, is_nl, squeeze, num, accept, is_ctrl;
  logic [LN_W-1:0] ln, ln_inc;
  logic [7:0]      c;
  logic [NUMBER_DIGITS:0] nines;

  assign c      = item_i.in_byte;
  assign accept = push_i && !full_i;
  assign ls     = item_i.file_start ? 1'b1 : at_line_start_q;
  assign pb     = item_i.file_start ? 1'b0 : prior_blank_q;
  assign ln     = item_i.file_start ? LN_ONE : line_number_q;
  assign is_nl  = (c == tcof_pkg::CH_NL);
  assign squeeze = is_nl && ls && pb && cfg_i.squeeze_blank;
  assign num    = ls && (cfg_i.number_nonblank ? !is_nl : cfg_i.number_all);

  // Decimal increment: a digit steps when every digit below it is a nine.
  // The all-nines value is kept as it is.
  always_comb begin
    nines[0] = 1'b1;
    ln_inc   = ln;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      nines[i+1] = nines[i] && (ln[4*i +: 4] == 4'd9);
    end
    if (!nines[NUMBER_DIGITS]) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (nines[i]) begin
          ln_inc[4*i +: 4] = (ln[4*i +: 4] == 4'd9) ? 4'd0 : ln[4*i +: 4] + 4'd1;
        end
      end
    end
  end

  assign is_ctrl = (c <= tcof_pkg::CH_CTRL_MAX) && (c != tcof_pkg::CH_TAB) && !is_nl;

  always_comb begin
    cmd_o.num    = num;
    cmd_o.dollar = cfg_i.show_ends && is_nl;
    cmd_o.caret  = 1'b0;
    cmd_o.chr    = c;
    if (cfg_i.show_tabs && (c == tcof_pkg::CH_TAB)) begin
      cmd_o.caret = 1'b1;
      cmd_o.chr   = tcof_pkg::CH_CAP_I;
    end else if (cfg_i.show_nonprinting && is_ctrl) begin
      cmd_o.caret = 1'b1;
      cmd_o.chr   = c + tcof_pkg::CARET_OFFSET;
    end else if (cfg_i.show_nonprinting && (c == tcof_pkg::CH_DEL)) begin
      cmd_o.caret = 1'b1;
      cmd_o.chr   = tcof_pkg::CH_QUEST;
    end
  end

  assign digits_o = ln;
  assign wr_o     = accept && !squeeze;

  always_comb begin
    at_line_start_d = at_line_start_q;
    prior_blank_d   = prior_blank_q;
    line_number_d   = line_number_q;
    if (accept) begin
      if (squeeze) begin
        at_line_start_d = ls;
        prior_blank_d   = pb;
        line_number_d   = ln;
      end else begin
        at_line_start_d = is_nl;
        prior_blank_d   = is_nl && ls;
        line_number_d   = num ? ln_inc : ln;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      prior_blank_q   <= 1'b0;
      line_number_q   <= LN_ONE;
    end else begin
      at_line_start_q <= at_line_start_d;
      prior_blank_q   <= prior_blank_d;
      line_number_q   <= line_number_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcof_queue.sv
// Short first-word-fall-through queue that decouples front and back.
// Depends on nothing but its parameters.
`default_nettype none

module tcof_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_i,
  input  wire  [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  wire              rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcof_back.sv
// Back end of the formatter: expands the queued head command into output
// bytes, one per cycle while popped, into a single output register.
// Depends on tcof_pkg.
`default_nettype none

module tcof_back #(
  parameter int NUMBER_DIGITS = tcof_pkg::NUMBER_DIGITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  tcof_pkg::cmd_t             cmd_i,
  input  wire  [NUMBER_DIGITS*4-1:0] digits_i,
  output logic                       rd_o,
  input  wire                        pop_i,
  output logic                       empty_o,
  output tcof_pkg::out_item_t        out_o
);

  localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [DIG_W-1:0] TOP_DIG = DIG_W'(NUMBER_DIGITS - 1);

  logic [NUMBER_DIGITS-1:0][3:0] digits;
  tcof_pkg::phase_e    phase_q, phase_d, phase, start_phase, after_tab, next_phase;
  logic                started_q, started_d, lead_q, lead_d, lead, lead_n;
  logic [DIG_W-1:0]    dig_q, dig_d, dig;
  logic [3:0]          d;
  logic                fire, is_last, out_valid_q, out_valid_d;
  logic [7:0]          byte_n;
  tcof_pkg::out_item_t out_q, out_d;

  assign digits  = digits_i;
  assign fire    = valid_i && (!out_valid_q || pop_i);
  assign phase   = started_q ? phase_q : start_phase;
  assign dig     = started_q ? dig_q : TOP_DIG;
  assign lead    = started_q ? lead_q : 1'b1;
  assign d       = (digits[dig] > 4'd9) ? 4'd9 : digits[dig];

  always_comb begin
    after_tab = cmd_i.dollar ? tcof_pkg::PH_DOLLAR :
                cmd_i.caret  ? tcof_pkg::PH_CARET  : tcof_pkg::PH_CHAR;
    start_phase = cmd_i.num ? tcof_pkg::PH_DIGIT : after_tab;
  end

  always_comb begin
    byte_n     = cmd_i.chr;
    is_last    = 1'b0;
    next_phase = tcof_pkg::PH_CHAR;
    lead_n     = lead;
    case (phase)
      tcof_pkg::PH_DIGIT: begin
        if (lead && (d == 4'd0) && (dig != '0)) begin
          byte_n = tcof_pkg::CH_SPACE;
        end else begin
          byte_n = tcof_pkg::CH_ZERO + {4'd0, d};
          lead_n = 1'b0;
        end
        next_phase = (dig != '0) ? tcof_pkg::PH_DIGIT : tcof_pkg::PH_TAB;
      end
      tcof_pkg::PH_TAB: begin
        byte_n     = tcof_pkg::CH_TAB;
        next_phase = after_tab;
      end
      tcof_pkg::PH_DOLLAR: begin
        byte_n     = tcof_pkg::CH_DOLLAR;
        next_phase = cmd_i.caret ? tcof_pkg::PH_CARET : tcof_pkg::PH_CHAR;
      end
      tcof_pkg::PH_CARET: begin
        byte_n     = tcof_pkg::CH_CARET;
        next_phase = tcof_pkg::PH_CHAR;
      end
      default: begin
        byte_n  = cmd_i.chr;
        is_last = 1'b1;
      end
    endcase
  end

  assign rd_o = fire && is_last;

  always_comb begin
    started_d   = started_q;
    phase_d     = phase_q;
    dig_d       = dig_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire) begin
      started_d      = !is_last;
      phase_d        = next_phase;
      dig_d          = dig - 1'b1;
      lead_d         = lead_n;
      out_valid_d    = 1'b1;
      out_d.out_byte = byte_n;
      out_d.last     = is_last;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      phase_q     <= tcof_pkg::PH_CHAR;
      dig_q       <= '0;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      phase_q     <= phase_d;
      dig_q       <= dig_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire
